// ===== rtl/ukfq_pkg.sv =====
// Package for the unique-key FIFO queue.
// Holds the queue depth, derived widths, action and status codes and the cell control struct.
// No dependencies.
package ukfq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PCMP_W      = (CNT_W > 8) ? CNT_W : 8;

  localparam int KEY_W   = 16;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int TOTAL_W = 5;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 56;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [VALUE_W-1:0] value_t;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DUP   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic occupied;
  } cell_ctl_t;

endpackage

// ===== rtl/ukfq_cell.sv =====
// One queue slot: holds a key and value pair and compares its key with a lookup key.
// Depends on ukfq_pkg.
module ukfq_cell import ukfq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  key_t      ins_key,
  input  value_t    ins_value,
  input  key_t      next_key,
  input  value_t    next_value,
  input  key_t      cmp_key,
  output key_t      cell_key,
  output value_t    cell_value,
  output logic      match
);

  key_t   key_r;
  value_t value_r;

  // advance toward the head on a pop, otherwise take the inserted pair on a load
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key_r   <= next_key;
      value_r <= next_value;
    end else if (ctl.load) begin
      key_r   <= ins_key;
      value_r <= ins_value;
    end
  end

  assign cell_key   = key_r;
  assign cell_value = value_r;
  assign match      = ctl.occupied && (key_r == cmp_key);

endmodule

// ===== rtl/unique_key_fifo_queue.sv =====
// Top level of the unique-key FIFO queue: a row of slot cells, an entry counter and
// an output register. Depends on ukfq_pkg and ukfq_cell.
//
// Each request word gives exactly one result word. Every cell compares its key with
// the request key in parallel and on a pop all cells shift one place toward the head
// in the same edge, so a new word is taken every cycle while the result register is
// free or being drained; the result is registered and appears in the cycle after
// acceptance. Reset clears only the count and output valid; the queue starts empty.
module unique_key_fifo_queue import ukfq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] action, [17:2] key, [49:18] value, [57:50] position, [63:58] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] status, [17:2] out_key, [49:18] out_value, [54:50] entry_total, [55] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  action_t            act;
  key_t               req_key;
  value_t             req_value;
  logic [POS_W-1:0]   req_pos;

  logic               in_accept;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  key_t               cell_key   [QUEUE_DEPTH];
  value_t             cell_value [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] match_vec;

  logic               dup;
  logic               full;
  logic               empty;
  logic               ins_ok;
  logic               pop_ok;
  logic [PCMP_W-1:0]  pos_ext;
  logic [PCMP_W-1:0]  cnt_ext;
  logic               pos_ok;
  logic [IDX_W-1:0]   rd_idx;

  status_t            st_nxt;
  key_t               rk_nxt;
  value_t             rv_nxt;

  assign act       = action_t'(in_tdata[1:0]);
  assign req_key   = in_tdata[17:2];
  assign req_value = in_tdata[49:18];
  assign req_pos   = in_tdata[57:50];

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  assign dup     = |match_vec;
  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign ins_ok  = in_accept && (act == ACT_INSERT) && !dup && !full;
  assign pop_ok  = in_accept && (act == ACT_POP) && !empty;

  assign pos_ext = PCMP_W'(req_pos);
  assign cnt_ext = PCMP_W'(count_r);
  assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign rd_idx  = IDX_W'(pos_ext - PCMP_W'(1));

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    key_t      nk;
    value_t    nv;

    assign ctl.shift    = pop_ok;
    assign ctl.load     = ins_ok && (count_r == CNT_W'(i));
    assign ctl.occupied = (CNT_W'(i) < count_r);

    if (i < QUEUE_DEPTH - 1) begin : g_mid
      assign nk = cell_key[i+1];
      assign nv = cell_value[i+1];
    end else begin : g_last
      assign nk = '0;
      assign nv = '0;
    end

    ukfq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .ins_key    (req_key),
      .ins_value  (req_value),
      .next_key   (nk),
      .next_value (nv),
      .cmp_key    (req_key),
      .cell_key   (cell_key[i]),
      .cell_value (cell_value[i]),
      .match      (match_vec[i])
    );
  end

  always_comb begin
    st_nxt    = ST_OK;
    rk_nxt    = '0;
    rv_nxt    = '0;
    count_nxt = count_r;
    case (act)
      ACT_INSERT: begin
        if (dup) begin
          st_nxt = ST_DUP;
        end else if (full) begin
          st_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_POP: begin
        if (empty) begin
          st_nxt = ST_EMPTY;
        end else begin
          rk_nxt    = cell_key[0];
          rv_nxt    = cell_value[0];
          count_nxt = count_r - CNT_W'(1);
        end
      end
      ACT_PEEK: begin
        if (empty) begin
          st_nxt = ST_EMPTY;
        end else begin
          rk_nxt = cell_key[0];
          rv_nxt = cell_value[0];
        end
      end
      ACT_READ: begin
        if (!pos_ok) begin
          st_nxt = ST_EMPTY;
        end else begin
          rk_nxt = cell_key[rd_idx];
          rv_nxt = cell_value[rd_idx];
        end
      end
      default: begin
        st_nxt = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      count_r     <= count_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= {1'b0, TOTAL_W'(count_nxt), rv_nxt, rk_nxt, st_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> count_r == CNT_W'($past(count_r) + CNT_W'(1)))
    else $error("accepted insert did not grow the queue");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ok |=> count_r == CNT_W'($past(count_r) - CNT_W'(1)))
    else $error("accepted pop did not shrink the queue");

  a_reads_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (act == ACT_PEEK || act == ACT_READ) |=> $stable(count_r))
    else $error("peek or position read changed the entry count");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_accept))
    else $error("result word without an accepted request");

endmodule
